>>> hdl/dsv_pkg.sv
// Package for the datetime string validator.
// Holds the word types, state type, error codes and check constants.
// Used by every module under hdl.
package dsv_pkg;

  localparam int unsigned PosW = 5;
  localparam int unsigned NumFlags = 9;

  localparam logic [PosW-1:0] StrLen  = PosW'(25);
  localparam logic [PosW-1:0] TypeIdx = PosW'(21);
  localparam logic [PosW-1:0] DotIdx  = PosW'(14);

  localparam logic [PosW-1:0] MonthIdx = PosW'(5);
  localparam logic [PosW-1:0] DayIdx   = PosW'(7);
  localparam logic [PosW-1:0] HourIdx  = PosW'(9);
  localparam logic [PosW-1:0] MinIdx   = PosW'(11);
  localparam logic [PosW-1:0] SecIdx   = PosW'(13);

  localparam logic [7:0] MonthMax  = 8'd12;
  localparam logic [7:0] DayMax    = 8'd31;
  localparam logic [7:0] HourMax   = 8'd24;
  localparam logic [7:0] MinSecMax = 8'd59;

  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChDot   = 8'h2e;
  localparam logic [7:0] ChColon = 8'h3a;
  localparam logic [7:0] ChPlus  = 8'h2b;
  localparam logic [7:0] ChMinus = 8'h2d;

  // flag bit positions
  localparam int unsigned FlgLen   = 0;
  localparam int unsigned FlgType  = 1;
  localparam int unsigned FlgDot   = 2;
  localparam int unsigned FlgDigit = 3;
  localparam int unsigned FlgMonth = 4;
  localparam int unsigned FlgDay   = 5;
  localparam int unsigned FlgHour  = 6;
  localparam int unsigned FlgMin   = 7;
  localparam int unsigned FlgSec   = 8;

  typedef enum logic [3:0] {
    ErrNone   = 4'd0,
    ErrLen    = 4'd1,
    ErrType   = 4'd2,
    ErrDot    = 4'd3,
    ErrDigit  = 4'd4,
    ErrMonth  = 4'd5,
    ErrDay    = 4'd6,
    ErrHour   = 4'd7,
    ErrMinute = 4'd8,
    ErrSecond = 4'd9
  } err_e;

  typedef struct packed {
    logic [7:0] char_in;
    logic       last_char;
  } in_t;

  typedef struct packed {
    logic       is_valid;
    logic       is_interval;
    logic [3:0] error_code;
  } out_t;

  typedef struct packed {
    logic [PosW-1:0]     pos;
    logic [3:0]          tens;
    logic [NumFlags-1:0] flags;
    logic                imk;
  } st_t;

  localparam st_t StReset = '{pos: '0, tens: '0, flags: '0, imk: 1'b1};

endpackage

>>> hdl/dsv_check.sv
// Per-byte check logic: next scan state and the result for a final byte.
// Depends on dsv_pkg.
module dsv_check import dsv_pkg::*; (
  input  st_t  st_i,
  input  in_t  word_i,
  output st_t  st_o,
  output out_t res_o
);

  logic [7:0]          c;
  logic [3:0]          d;
  logic [7:0]          val;
  logic                dig;
  st_t                 nxt;
  logic [NumFlags-1:0] fin;
  logic                intv;
  logic [3:0]          code;

  always_comb begin
    c   = word_i.char_in;
    d   = c[3:0];
    val = 8'({4'b0, st_i.tens} * 8'd10) + {4'b0, d};
    dig = c inside {[ChZero:ChNine]};
    nxt = st_i;

    if (st_i.pos < StrLen) begin
      if (st_i.pos != DotIdx && st_i.pos != TypeIdx && !dig) nxt.flags[FlgDigit] = 1'b1;

      if (st_i.pos == DotIdx) begin
        if (c != ChDot) nxt.flags[FlgDot] = 1'b1;
      end else if (st_i.pos == TypeIdx) begin
        if (c == ChPlus || c == ChMinus) begin
          nxt.imk = 1'b0;
        end else if (c != ChColon) begin
          nxt.imk = 1'b0;
          nxt.flags[FlgType] = 1'b1;
        end
      end else if (st_i.pos > TypeIdx) begin
        if (c != ChZero && st_i.imk) begin
          nxt.imk = 1'b0;
          nxt.flags[FlgType] = 1'b1;
        end
      end

      case (st_i.pos)
        5'd4, 5'd6, 5'd8, 5'd10, 5'd12: nxt.tens = d;
        MonthIdx: if (val == 8'd0 || val > MonthMax) nxt.flags[FlgMonth] = 1'b1;
        DayIdx:   if (val == 8'd0 || val > DayMax) nxt.flags[FlgDay] = 1'b1;
        HourIdx:  if (val > HourMax) nxt.flags[FlgHour] = 1'b1;
        MinIdx:   if (val > MinSecMax) nxt.flags[FlgMin] = 1'b1;
        SecIdx:   if (val > MinSecMax) nxt.flags[FlgSec] = 1'b1;
        default: ;
      endcase

      nxt.pos = st_i.pos + PosW'(1);
    end else begin
      nxt.flags[FlgLen] = 1'b1;
    end

    fin = nxt.flags;
    if (nxt.pos != StrLen) fin[FlgLen] = 1'b1;
    intv = !fin[FlgLen] && nxt.imk;
    if (intv) begin
      fin[FlgMonth] = 1'b0;
      fin[FlgDay]   = 1'b0;
    end

    // lowest set flag wins
    code = ErrNone;
    for (int i = NumFlags - 1; i >= 0; i--) begin
      if (fin[i]) code = 4'(i + 1);
    end

    res_o.is_valid    = (code == ErrNone);
    res_o.is_interval = intv;
    res_o.error_code  = code;
    st_o = word_i.last_char ? StReset : nxt;
  end

endmodule

>>> hdl/dsv_out_buf.sv
// Two-entry result buffer: output register plus skid register.
// Depends on dsv_pkg.
module dsv_out_buf import dsv_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  out_t data_i,
  output logic full_o,
  output logic valid_o,
  input  logic stall_i,
  output out_t data_o
);

  logic main_vld_q, main_vld_d;
  logic skid_vld_q, skid_vld_d;
  out_t main_q, main_d;
  out_t skid_q, skid_d;
  logic pop;

  assign pop = main_vld_q && !stall_i;

  always_comb begin
    main_vld_d = main_vld_q;
    skid_vld_d = skid_vld_q;
    main_d     = main_q;
    skid_d     = skid_q;
    if (skid_vld_q) begin
      if (pop) begin
        main_d     = skid_q;
        skid_vld_d = 1'b0;
      end
    end else begin
      main_vld_d = push_i || (main_vld_q && !pop);
      if (push_i && (!main_vld_q || pop)) main_d = data_i;
      if (push_i && main_vld_q && !pop) begin
        skid_vld_d = 1'b1;
        skid_d     = data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      main_vld_q <= main_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign full_o  = skid_vld_q;
  assign valid_o = main_vld_q;
  assign data_o  = main_q;

endmodule

>>> hdl/datetime_string_validator_unit.sv
// Datetime string validator, top level: scan state register, check logic, result buffer.
// Takes one byte per cycle unless stalled; the last byte's result word is registered.
// Throughput 1 byte/cycle unless stalled; state-to-result check logic is combinational.
// Input stalls while both result registers are full; releases the cycle after a word leaves.
// Async active-low reset clears scan state (position 0, flags clear) and empties the buffer.
// Depends on dsv_pkg, dsv_check, dsv_out_buf.
module datetime_string_validator_unit import dsv_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_word_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_word_o
);

  st_t  st_q, st_d, st_nxt;
  out_t res;
  logic acc;
  logic full;

  assign in_stall_o = full;
  assign acc        = in_valid_i && !full;

  dsv_check u_check (
    .st_i   (st_q),
    .word_i (in_word_i),
    .st_o   (st_nxt),
    .res_o  (res)
  );

  assign st_d = acc ? st_nxt : st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StReset;
    end else begin
      st_q <= st_d;
    end
  end

  dsv_out_buf u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (acc && in_word_i.last_char),
    .data_i  (res),
    .full_o  (full),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_word_o)
  );

endmodule

>>> hdl/dsv_checker.sv
// Port-level checker for the datetime string validator, with its bind.
// Depends on dsv_pkg and datetime_string_validator_unit.
module dsv_checker import dsv_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input in_t  in_word_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_word_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_word_i.last_char |=> out_valid_o)
    else $error("no result after last byte");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stalled without a blocked result");

  a_code_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.is_valid == (out_word_o.error_code == ErrNone)) &&
                    !(out_word_o.is_interval && out_word_o.error_code == ErrLen))
    else $error("inconsistent result word");

endmodule

bind datetime_string_validator_unit dsv_checker u_dsv_checker (.*);

>>> tb/datetime_string_validator_unit_tb.sv
// Testbench for datetime_string_validator_unit: streams 25-byte datetime strings
// and malformed byte runs, predicts each result word and checks it field by field.
// Depends on dsv_pkg and the RTL under hdl.
`timescale 1ns / 100ps

module datetime_string_validator_unit_tb;
  import dsv_pkg::*;

  localparam int unsigned ClkPeriod     = 20;
  localparam int unsigned ResetCycles   = 6;
  localparam int unsigned DrainCycles   = 4;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned RandomItems   = 1450;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic out_stall_i = 1'b0;
  in_t  in_word_i   = '0;
  logic in_stall_o;
  logic out_valid_o;
  out_t out_word_o;

  datetime_string_validator_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // scan state of the predictor
  logic [PosW-1:0]     scan_pos   = '0;
  logic [3:0]          scan_tens  = '0;
  logic [NumFlags-1:0] scan_flags = '0;
  logic                marker_ok  = 1'b1;

  out_t        verdict_q[$];
  logic [7:0]  seq_q[$];
  int unsigned gap_max     = 0;
  int unsigned stall_max   = 0;
  int unsigned next_gap    = 0;
  int unsigned hold_req    = 0;
  int unsigned n_items     = 0;
  int unsigned n_errors    = 0;
  int unsigned quiet_count = 0;

  // Advances the scan by one byte; returns 1 and the verdict on the last byte.
  function automatic bit judge_char(input in_t w, output out_t verdict);
    logic [7:0]          c;
    logic [3:0]          d;
    logic [7:0]          val;
    logic                is_digit;
    logic                interval;
    logic [NumFlags-1:0] f;
    err_e                code;
    c = w.char_in;
    verdict = '0;
    if (scan_pos < StrLen) begin
      d = 4'(c - ChZero);
      val = 8'(scan_tens * 10 + d);
      is_digit = (c >= ChZero) && (c <= ChNine);
      if (scan_pos != DotIdx && scan_pos != TypeIdx && !is_digit) scan_flags[FlgDigit] = 1'b1;
      if (scan_pos == DotIdx) begin
        if (c != ChDot) scan_flags[FlgDot] = 1'b1;
      end else if (scan_pos == TypeIdx) begin
        if (c == ChPlus || c == ChMinus) begin
          marker_ok = 1'b0;
        end else if (c != ChColon) begin
          marker_ok = 1'b0;
          scan_flags[FlgType] = 1'b1;
        end
      end else if (scan_pos > TypeIdx) begin
        if (c != ChZero && marker_ok) begin
          marker_ok = 1'b0;
          scan_flags[FlgType] = 1'b1;
        end
      end
      case (scan_pos)
        5'd4, 5'd6, 5'd8, 5'd10, 5'd12: scan_tens = d;
        MonthIdx: if (val == 0 || val > MonthMax) scan_flags[FlgMonth] = 1'b1;
        DayIdx:   if (val == 0 || val > DayMax) scan_flags[FlgDay] = 1'b1;
        HourIdx:  if (val > HourMax) scan_flags[FlgHour] = 1'b1;
        MinIdx:   if (val > MinSecMax) scan_flags[FlgMin] = 1'b1;
        SecIdx:   if (val > MinSecMax) scan_flags[FlgSec] = 1'b1;
        default: ;
      endcase
      scan_pos++;
    end else begin
      scan_flags[FlgLen] = 1'b1;
    end
    if (!w.last_char) return 1'b0;
    f = scan_flags;
    if (scan_pos != StrLen) f[FlgLen] = 1'b1;
    interval = !f[FlgLen] && marker_ok;
    if (interval) begin
      f[FlgMonth] = 1'b0;
      f[FlgDay] = 1'b0;
    end
    code = ErrNone;
    for (int i = NumFlags - 1; i >= 0; i--) begin
      if (f[i]) code = err_e'(i + 1);
    end
    verdict.is_valid = (code == ErrNone);
    verdict.is_interval = interval;
    verdict.error_code = code;
    scan_pos = '0;
    scan_tens = '0;
    scan_flags = '0;
    marker_ok = 1'b1;
    return 1'b1;
  endfunction

  task automatic send_item(input logic [7:0] ch, input logic last);
    out_t verdict;
    repeat (next_gap) @(posedge clk_i);
    in_valid_i <= 1'b1;
    in_word_i <= '{char_in: ch, last_char: last};
    do @(posedge clk_i); while (in_stall_o);
    n_items++;
    if (judge_char(in_word_i, verdict)) verdict_q.push_back(verdict);
    next_gap = $urandom_range(0, gap_max);
    if (next_gap != 0) in_valid_i <= 1'b0;
  endtask

  task automatic send_seq();
    foreach (seq_q[i]) send_item(seq_q[i], i == seq_q.size() - 1);
  endtask

  task automatic wait_drain();
    if (next_gap == 0) begin
      in_valid_i <= 1'b0;
      next_gap = 1;
    end
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic void load_text(input string t);
    seq_q.delete();
    for (int i = 0; i < t.len(); i++) seq_q.push_back(t[i]);
  endfunction

  function automatic void push_digit();
    seq_q.push_back(8'($urandom_range(ChZero, ChNine)));
  endfunction

  function automatic void push_num2(input int unsigned v);
    seq_q.push_back(8'(ChZero + v / 10));
    seq_q.push_back(8'(ChZero + v % 10));
  endfunction

  function automatic void build_datetime(input bit interval);
    seq_q.delete();
    if (interval) begin
      repeat (8) push_digit();
    end else begin
      repeat (4) push_digit();
      push_num2($urandom_range(1, 12));
      push_num2($urandom_range(1, 31));
    end
    push_num2($urandom_range(0, 24));
    push_num2($urandom_range(0, 59));
    push_num2($urandom_range(0, 59));
    seq_q.push_back(ChDot);
    repeat (6) push_digit();
    if (interval) begin
      seq_q.push_back(ChColon);
      repeat (3) seq_q.push_back(ChZero);
    end else begin
      seq_q.push_back($urandom_range(0, 1) ? ChPlus : ChMinus);
      repeat (3) push_digit();
    end
  endfunction

  task automatic test_directed();
    string cases[$];
    cases = '{
      "20240229123456.123456+060", "19991231245959.999999-720",
      "00000101000000.000000+000", "12345678235959.000000:000",
      "00000000000000.000000:000", "99999999999999.999999:000",
      "20241301000000.000000+000", "20240001000000.000000+000",
      "20240100000000.000000+000", "20240132000000.000000+000",
      "20240101250000.000000+000", "20240101006000.000000+000",
      "20240101000060.000000+000", "20240101000000.000000:001",
      "20240101000000.000000*000", "20240101000000,000000+000",
      "2024010100000x.000000+000", "2024A101000000.000000+000",
      "20240101000000.000000+00",  "20240101000000.000000+0000"
    };
    gap_max = 15;
    stall_max = 15;
    foreach (cases[i]) begin
      load_text(cases[i]);
      send_seq();
    end
    load_text(cases[0]);
    seq_q[2] = 8'h00;
    send_seq();
    load_text(cases[0]);
    seq_q[20] = 8'hff;
    send_seq();
    load_text(cases[1]);
    repeat (15) seq_q.push_back(ChZero);
    send_seq();
    send_item(ChNine, 1'b1);
  endtask

  task automatic test_backpressure();
    gap_max = 0;
    stall_max = 0;
    hold_req = HoldCycles;
    repeat (40) send_item(8'($urandom_range(0, 255)), 1'b1);
    build_datetime(1'b0);
    send_seq();
  endtask

  task automatic test_random();
    int unsigned p;
    int unsigned v;
    while (n_items < RandomItems) begin
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
      stall_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
      if ($urandom_range(0, 9) == 0) begin
        seq_q.delete();
        repeat ($urandom_range(1, 30)) begin
          if ($urandom_range(0, 1)) push_digit();
          else seq_q.push_back(8'($urandom_range(0, 255)));
        end
      end else begin
        build_datetime($urandom_range(0, 2) == 0);
        if ($urandom_range(0, 1)) begin
          case ($urandom_range(0, 6))
            0: seq_q[$urandom_range(0, seq_q.size() - 1)] = 8'($urandom_range(0, 255));
            1: begin
              p = 4 + 2 * $urandom_range(0, 4);
              v = $urandom_range(0, 99);
              seq_q[p] = 8'(ChZero + v / 10);
              seq_q[p + 1] = 8'(ChZero + v % 10);
            end
            2: begin
              v = $urandom_range(1, seq_q.size() - 1);
              while (seq_q.size() > v) void'(seq_q.pop_back());
            end
            3: repeat ($urandom_range(1, 5)) push_digit();
            4: seq_q[$urandom_range(TypeIdx, StrLen - 1)] =
                 $urandom_range(0, 1) ? ChColon : 8'($urandom_range(ChPlus, ChNine));
            5: seq_q[DotIdx] = 8'($urandom_range(0, 255));
            default: seq_q[4 + $urandom_range(0, 9)] = 8'($urandom_range(0, 255));
          endcase
        end
      end
      send_seq();
    end
  endtask

  task automatic test_drain_pause();
    gap_max = 15;
    stall_max = 15;
    repeat (4) begin
      build_datetime($urandom_range(0, 1));
      send_seq();
      wait_drain();
    end
  endtask

  // receiver: random stall per word, plus the long hold-off on request
  initial begin : out_side
    int unsigned stall_left;
    int unsigned hold_left;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (out_valid_o && !out_stall_i) stall_left = $urandom_range(0, stall_max);
        if (stall_left != 0) begin
          stall_left--;
          out_stall_i <= 1'b1;
        end else begin
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (verdict_q.size() == 0) begin
        $error("unexpected result word %p", out_word_o);
        n_errors++;
      end else begin
        want = verdict_q.pop_front();
        if (out_word_o.is_valid !== want.is_valid) begin
          $error("is_valid: expected %0d, got %0d", want.is_valid, out_word_o.is_valid);
          n_errors++;
        end
        if (out_word_o.is_interval !== want.is_interval) begin
          $error("is_interval: expected %0d, got %0d", want.is_interval,
                 out_word_o.is_interval);
          n_errors++;
        end
        if (out_word_o.error_code !== want.error_code) begin
          $error("error_code: expected %0d, got %0d", want.error_code, out_word_o.error_code);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_count <= 0;
      end else if (quiet_count >= WatchdogLimit) begin
        $display("datetime_string_validator_unit_tb: FAIL");
        $finish;
      end else begin
        quiet_count <= quiet_count + 1;
      end
    end
  end

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random();
    test_drain_pause();
    wait_drain();
    if (verdict_q.size() != 0) begin
      $error("%0d result words never arrived", verdict_q.size());
      n_errors++;
    end
    if (n_errors == 0) begin
      $display("datetime_string_validator_unit_tb: PASS");
    end else begin
      $display("datetime_string_validator_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/dsv_pkg.sv
hdl/dsv_check.sv
hdl/dsv_out_buf.sv
hdl/datetime_string_validator_unit.sv
hdl/dsv_checker.sv
tb/datetime_string_validator_unit_tb.sv
